/* sv/csp_pkg.sv */
// Shared types and constants for the CIGAR string parser.
package csp_pkg;

  localparam int CSP_LENGTH_BITS = 32;
  localparam int CSP_QUEUE_DEPTH = 4;
  localparam int CSP_PTR_W       = $clog2(CSP_QUEUE_DEPTH);
  localparam int CSP_CNT_W       = $clog2(CSP_QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    OP_MATCH  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CHANGE = 2'd3
  } edit_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SIZE  = 3'd1,
    ST_BAD_CODE = 3'd2,
    ST_NO_CODE  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // One queue entry: results caused by one request (edit and/or summary).
  typedef struct packed {
    logic        has_edit;
    logic        has_sum;
    logic [31:0] run_length;
    edit_op_t    edit_op;
    logic [31:0] reference_total;
    logic [31:0] alternate_total;
    status_t     status;
  } csp_entry_t;

endpackage

/* sv/csp_core.sv */
// Input register, parse state and result formation for the CIGAR parser.
module csp_core import csp_pkg::*; #(
  parameter int LENGTH_BITS = CSP_LENGTH_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_char,
  input  logic                 in_end_of_string,
  input  logic [CSP_CNT_W-1:0] q_count,
  output logic                 q_push,
  output csp_entry_t           q_entry
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic                   s1_valid_r;
  logic [7:0]             s1_char_r;
  logic                   s1_last_r;

  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic                   dig_r, dig_nxt;
  logic [LENGTH_BITS-1:0] ref_r, ref_nxt;
  logic [LENGTH_BITS-1:0] alt_r, alt_nxt;
  status_t                err_r, err_nxt;

  logic                   in_fire;
  logic                   is_digit;
  logic [LENGTH_BITS+3:0] acc_ext;
  logic [LENGTH_BITS+3:0] prod;
  logic                   op_valid;
  edit_op_t               op;
  logic                   use_ref;
  logic                   use_alt;
  logic [LENGTH_BITS:0]   ref_add;
  logic [LENGTH_BITS:0]   alt_add;
  logic                   edit_v;
  logic [LENGTH_BITS-1:0] ref_upd;
  logic [LENGTH_BITS-1:0] alt_upd;
  status_t                err_upd;

  // Room for the entry in flight plus the new one.
  assign in_stall = (int'(q_count) + int'(s1_valid_r) + 1) > CSP_QUEUE_DEPTH;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_text_char;
      s1_last_r <= in_end_of_string;
    end
  end

  assign is_digit = s1_char_r inside {[CH_ZERO:CH_NINE]};
  assign acc_ext  = {4'b0000, acc_r};
  // acc * 10 + digit
  assign prod     = (acc_ext << 3) + (acc_ext << 1)
                  + {{LENGTH_BITS{1'b0}}, s1_char_r[3:0]};

  always_comb begin
    op_valid = 1'b1;
    op       = OP_MATCH;
    use_ref  = 1'b0;
    use_alt  = 1'b0;
    case (s1_char_r)
      CH_M: begin
        op = OP_MATCH;  use_ref = 1'b1; use_alt = 1'b1;
      end
      CH_I: begin
        op = OP_INSERT; use_alt = 1'b1;
      end
      CH_D: begin
        op = OP_DELETE; use_ref = 1'b1;
      end
      CH_X: begin
        op = OP_CHANGE; use_ref = 1'b1; use_alt = 1'b1;
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase
  end

  assign ref_add = {1'b0, ref_r} + {1'b0, acc_r};
  assign alt_add = {1'b0, alt_r} + {1'b0, acc_r};

  always_comb begin
    acc_nxt = acc_r;
    dig_nxt = dig_r;
    ref_upd = ref_r;
    alt_upd = alt_r;
    err_upd = err_r;
    edit_v  = 1'b0;
    if (err_r == ST_OK) begin
      if (is_digit) begin
        if (|prod[LENGTH_BITS+3:LENGTH_BITS]) begin
          acc_nxt = LEN_MAX;
          err_upd = ST_OVERFLOW;
        end else begin
          acc_nxt = prod[LENGTH_BITS-1:0];
        end
        dig_nxt = 1'b1;
      end else if (!dig_r) begin
        err_upd = ST_NO_SIZE;
      end else if (!op_valid) begin
        err_upd = ST_BAD_CODE;
      end else begin
        edit_v  = 1'b1;
        acc_nxt = '0;
        dig_nxt = 1'b0;
        if (use_ref) begin
          ref_upd = ref_add[LENGTH_BITS] ? LEN_MAX : ref_add[LENGTH_BITS-1:0];
          if (ref_add[LENGTH_BITS]) err_upd = ST_OVERFLOW;
        end
        if (use_alt) begin
          alt_upd = alt_add[LENGTH_BITS] ? LEN_MAX : alt_add[LENGTH_BITS-1:0];
          if (alt_add[LENGTH_BITS]) err_upd = ST_OVERFLOW;
        end
      end
    end
    if (s1_last_r && (err_upd == ST_OK) && dig_nxt) begin
      err_upd = ST_NO_CODE;
    end
    ref_nxt = ref_upd;
    alt_nxt = alt_upd;
    err_nxt = err_upd;
    // End of string returns to the idle parse state.
    if (s1_last_r) begin
      acc_nxt = '0;
      dig_nxt = 1'b0;
      ref_nxt = '0;
      alt_nxt = '0;
      err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      dig_r <= 1'b0;
      ref_r <= '0;
      alt_r <= '0;
      err_r <= ST_OK;
    end else if (s1_valid_r) begin
      acc_r <= acc_nxt;
      dig_r <= dig_nxt;
      ref_r <= ref_nxt;
      alt_r <= alt_nxt;
      err_r <= err_nxt;
    end
  end

  assign q_push = s1_valid_r && (edit_v || s1_last_r);

  always_comb begin
    q_entry.has_edit        = edit_v;
    q_entry.has_sum         = s1_last_r;
    q_entry.run_length      = 32'(acc_r);
    q_entry.edit_op         = op;
    q_entry.reference_total = 32'(ref_upd);
    q_entry.alternate_total = 32'(alt_upd);
    q_entry.status          = err_upd;
  end

endmodule

/* sv/csp_outq.sv */
// Result queue: holds per-request entries and unpacks them into result items.
module csp_outq import csp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_push,
  input  csp_entry_t           q_entry,
  output logic [CSP_CNT_W-1:0] q_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_item_kind,
  output logic [31:0]          out_run_length,
  output logic [1:0]           out_edit_op,
  output logic [31:0]          out_reference_total,
  output logic [31:0]          out_alternate_total,
  output logic [2:0]           out_parse_status,
  output logic                 out_last_result
);

  localparam logic [CSP_PTR_W-1:0] PTR_LAST = CSP_PTR_W'(CSP_QUEUE_DEPTH - 1);
  localparam logic [CSP_PTR_W-1:0] PTR_ONE  = CSP_PTR_W'(1);
  localparam logic [CSP_CNT_W-1:0] CNT_ONE  = CSP_CNT_W'(1);

  csp_entry_t           mem_r [CSP_QUEUE_DEPTH];
  logic [CSP_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CSP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 phase_r;
  csp_entry_t           head;
  logic                 show_edit;
  logic                 out_fire;
  logic                 deq;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (cnt_r != '0);
  assign show_edit = head.has_edit && !phase_r;
  assign out_fire  = out_valid && !out_stall;
  assign deq       = out_fire && !(show_edit && head.has_sum);
  assign q_count   = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !deq) cnt_nxt = cnt_r + CNT_ONE;
    else if (!q_push && deq) cnt_nxt = cnt_r - CNT_ONE;
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
        phase_r  <= 1'b0;
      end else if (out_fire) begin
        phase_r  <= 1'b1;
      end
    end
  end

  always_comb begin
    if (show_edit) begin
      out_item_kind       = 1'b0;
      out_run_length      = head.run_length;
      out_edit_op         = head.edit_op;
      out_reference_total = '0;
      out_alternate_total = '0;
      out_parse_status    = ST_OK;
      out_last_result     = !head.has_sum;
    end else begin
      out_item_kind       = 1'b1;
      out_run_length      = '0;
      out_edit_op         = OP_MATCH;
      out_reference_total = head.reference_total;
      out_alternate_total = head.alternate_total;
      out_parse_status    = head.status;
      out_last_result     = 1'b1;
    end
  end

endmodule

/* sv/cigar_string_parser.sv */
// An accepted request is held in the input register, then written into the result queue, whose head drives the outputs.
// Throughput: one request per cycle while in_stall is low; a request causing an edit item and a summary
//   gives two output items, absorbed by the 4-entry result queue.
// in_stall rises only when the result queue plus the input register could overflow.
// Reset: synchronous, active low; clears parse state, the input register's valid bit and queue pointers.
// Top level of the CIGAR string parser.
module cigar_string_parser import csp_pkg::*; #(
  parameter int LENGTH_BITS = CSP_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [31:0] out_run_length,
  output logic [1:0]  out_edit_op,
  output logic [31:0] out_reference_total,
  output logic [31:0] out_alternate_total,
  output logic [2:0]  out_parse_status,
  output logic        out_last_result
);

  // Queue occupancy feeds back to the input side for flow control.
  logic [CSP_CNT_W-1:0] q_count;
  logic                 q_push;
  csp_entry_t           q_entry;

  // Parse stage: registers the character, then updates run length, totals
  // and status in one pass (multiply by ten is shift-and-add).
  csp_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_char     (in_text_char),
    .in_end_of_string (in_end_of_string),
    .q_count          (q_count),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  // Result queue: one entry per request that yields a result, unpacked into edit item then summary.
  csp_outq u_outq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_push              (q_push),
    .q_entry             (q_entry),
    .q_count             (q_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_run_length      (out_run_length),
    .out_edit_op         (out_edit_op),
    .out_reference_total (out_reference_total),
    .out_alternate_total (out_alternate_total),
    .out_parse_status    (out_parse_status),
    .out_last_result     (out_last_result)
  );

endmodule

/* sv/csp_checker.sv */
// Port-level assertions for the CIGAR string parser, bound to the top level.
module csp_checker import csp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_item_kind,
  input logic [31:0] out_run_length,
  input logic [1:0]  out_edit_op,
  input logic [31:0] out_reference_total,
  input logic [31:0] out_alternate_total,
  input logic [2:0]  out_parse_status,
  input logic        out_last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item_kind)
      && $stable(out_run_length) && $stable(out_reference_total)
      && $stable(out_parse_status) && $stable(out_last_result))
    else $error("stalled result changed");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind |-> out_last_result)
    else $error("summary not marked last");

  a_edit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind |-> out_parse_status == ST_OK
      && out_reference_total == 32'd0 && out_alternate_total == 32'd0)
    else $error("edit item carries summary fields");

  a_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind |-> out_run_length == 32'd0 && out_edit_op == OP_MATCH)
    else $error("summary carries edit fields");

  a_edit_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item_kind && !out_last_result
      |=> out_valid && out_item_kind)
    else $error("non-last edit item not followed by summary");

endmodule

bind cigar_string_parser csp_checker u_csp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_item_kind       (out_item_kind),
  .out_run_length      (out_run_length),
  .out_edit_op         (out_edit_op),
  .out_reference_total (out_reference_total),
  .out_alternate_total (out_alternate_total),
  .out_parse_status    (out_parse_status),
  .out_last_result     (out_last_result)
);
